/* src/tep_pkg.sv */
// ----------------------------------------------------------------------------
// tep_pkg
// Shared types and constants of the timed event playback sequencer: command
// codes, input and result items, and the controller-to-datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package tep_pkg;

  localparam int MAX_EVENTS  = 256;
  localparam int EVENT_WIDTH = 32;
  localparam int ADDR_W      = $clog2(MAX_EVENTS);
  localparam int CNT_W       = $clog2(MAX_EVENTS + 1);
  localparam int WAIT_W      = 8;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 9;

  localparam logic [WAIT_W-1:0] DEFAULT_WAIT_RESET = WAIT_W'(1);

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_FORWARD   = 3'd1,
    CMD_REWIND    = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_PLAY      = 3'd4,
    CMD_BEGINNING = 3'd5,
    CMD_EJECT     = 3'd6,
    CMD_LOAD      = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [VALUE_W-1:0] event_value;
    logic [WAIT_W-1:0]  event_wait;
    logic               first_of_load;
  } in_item_t;

  typedef struct packed {
    logic               event_valid;
    logic [VALUE_W-1:0] event_out;
    logic               command_ok;
    logic               running_now;
    logic [POS_W-1:0]   position_now;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/tep_ctrl.sv */
// ----------------------------------------------------------------------------
// tep_ctrl
// Controller: takes one item, then commits it once the result register is
// free.
// ----------------------------------------------------------------------------
`default_nettype none

module tep_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  out_ready,
  input  tep_pkg::dp_status_t  status,
  output tep_pkg::ctrl_cmd_t   cmd
);

  tep_pkg::state_t state;
  tep_pkg::state_t state_next;
  logic            room;

  assign room = !status.out_full || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tep_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tep_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tep_pkg::ST_EXEC;
        end
      end
      tep_pkg::ST_EXEC: begin
        if (room) begin
          state_next = tep_pkg::ST_IDLE;
        end
      end
      default: state_next = tep_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      tep_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      tep_pkg::ST_EXEC: begin
        cmd.execute = room;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/tep_dp.sv */
// ----------------------------------------------------------------------------
// tep_dp
// Datapath: event and wait stores, transport state, tick counter, default
// wait register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tep_dp (
  input  wire                         clk,
  input  wire                         rst,
  input  tep_pkg::ctrl_cmd_t          cmd,
  output tep_pkg::dp_status_t         status,
  input  tep_pkg::in_item_t           in_data,
  input  wire                         cfg_valid,
  input  wire [tep_pkg::WAIT_W-1:0]   cfg_data,
  input  wire                         out_ready,
  output logic                        out_valid,
  output tep_pkg::out_item_t          out_data
);

  logic [tep_pkg::EVENT_WIDTH-1:0] event_store [tep_pkg::MAX_EVENTS];
  logic [tep_pkg::WAIT_W-1:0]      wait_override_store [tep_pkg::MAX_EVENTS];

  tep_pkg::in_item_t               item;
  logic [tep_pkg::EVENT_WIDTH-1:0] ev_rdata;
  logic [tep_pkg::WAIT_W-1:0]      wait_rdata;

  logic [tep_pkg::CNT_W-1:0]  event_count, event_count_next;
  logic [tep_pkg::CNT_W-1:0]  play_position, play_position_next;
  logic                       running_flag, running_flag_next;
  logic [tep_pkg::WAIT_W-1:0] current_wait, current_wait_next;
  logic [tep_pkg::WAIT_W-1:0] tick_counter, tick_counter_next;
  logic [tep_pkg::WAIT_W-1:0] default_wait;

  logic [tep_pkg::CNT_W-1:0]  pos_inc;
  logic [tep_pkg::WAIT_W-1:0] cnt_inc;
  logic                       load_ok;
  logic [tep_pkg::ADDR_W-1:0] load_addr;
  logic                       valid_next;
  logic [tep_pkg::VALUE_W-1:0] emitted_next;
  logic                       ok_next;

  assign status.out_full = out_valid;
  assign pos_inc = play_position + tep_pkg::CNT_W'(1);
  assign cnt_inc = (tick_counter != {tep_pkg::WAIT_W{1'b1}}) ?
                   tick_counter + tep_pkg::WAIT_W'(1) : tick_counter;
  assign load_ok = item.first_of_load ||
                   (event_count < tep_pkg::CNT_W'(tep_pkg::MAX_EVENTS));
  assign load_addr = item.first_of_load ? '0 : event_count[tep_pkg::ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item       <= in_data;
      ev_rdata   <= event_store[play_position[tep_pkg::ADDR_W-1:0]];
      wait_rdata <= wait_override_store[pos_inc[tep_pkg::ADDR_W-1:0]];
    end
    if (cmd.execute && item.command == tep_pkg::CMD_LOAD && load_ok) begin
      event_store[load_addr]         <= tep_pkg::EVENT_WIDTH'(item.event_value);
      wait_override_store[load_addr] <= item.event_wait;
    end
  end

  always_comb begin
    event_count_next   = event_count;
    play_position_next = play_position;
    running_flag_next  = running_flag;
    current_wait_next  = current_wait;
    tick_counter_next  = tick_counter;
    valid_next         = 1'b0;
    emitted_next       = '0;
    ok_next            = 1'b1;
    unique case (item.command)
      tep_pkg::CMD_TICK: begin
        if (running_flag) begin
          tick_counter_next = cnt_inc;
          if (cnt_inc >= current_wait) begin
            tick_counter_next = '0;
            if (play_position < event_count) begin
              valid_next         = 1'b1;
              emitted_next       = tep_pkg::VALUE_W'(ev_rdata);
              play_position_next = pos_inc;
              if (pos_inc < event_count && wait_rdata != '0) begin
                current_wait_next = wait_rdata;
              end else begin
                current_wait_next = default_wait;
              end
            end else begin
              running_flag_next  = 1'b0;
              play_position_next = '0;
            end
          end
        end
      end
      tep_pkg::CMD_FORWARD: begin
        if (play_position < event_count) begin
          play_position_next = pos_inc;
        end else begin
          ok_next = 1'b0;
        end
      end
      tep_pkg::CMD_REWIND: begin
        if (play_position != '0) begin
          play_position_next = play_position - tep_pkg::CNT_W'(1);
        end else begin
          ok_next = 1'b0;
        end
      end
      tep_pkg::CMD_STOP: begin
        running_flag_next = 1'b0;
      end
      tep_pkg::CMD_PLAY: begin
        running_flag_next = 1'b1;
      end
      tep_pkg::CMD_BEGINNING: begin
        running_flag_next  = 1'b0;
        play_position_next = '0;
      end
      tep_pkg::CMD_EJECT: begin
        event_count_next   = '0;
        running_flag_next  = 1'b0;
        play_position_next = '0;
      end
      tep_pkg::CMD_LOAD: begin
        if (item.first_of_load) begin
          running_flag_next  = 1'b0;
          play_position_next = '0;
        end
        if (load_ok) begin
          event_count_next = tep_pkg::CNT_W'(load_addr) + tep_pkg::CNT_W'(1);
        end else begin
          ok_next = 1'b0;
        end
      end
      default: begin
        ok_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count   <= '0;
      play_position <= '0;
      running_flag  <= 1'b0;
      current_wait  <= tep_pkg::DEFAULT_WAIT_RESET;
      tick_counter  <= '0;
      default_wait  <= tep_pkg::DEFAULT_WAIT_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        default_wait <= cfg_data;
      end
      if (cmd.execute) begin
        event_count   <= event_count_next;
        play_position <= play_position_next;
        running_flag  <= running_flag_next;
        current_wait  <= current_wait_next;
        tick_counter  <= tick_counter_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_data.event_valid  <= valid_next;
      out_data.event_out    <= emitted_next;
      out_data.command_ok   <= ok_next;
      out_data.running_now  <= running_flag_next;
      out_data.position_now <= tep_pkg::POS_W'(play_position_next);
    end
  end

endmodule

`default_nettype wire

/* src/timed_event_playback_sequencer_core.sv */
// ----------------------------------------------------------------------------
// timed_event_playback_sequencer_core
// Recorded event player: loads an event list, then replays it on ticks.
// The item and its store reads are registered when the input transfers; the
// result is registered at commit, delayed while an untaken result waits.
// Per item: take and store read, then commit; no new item before the commit.
// The next item is taken while a result still waits in the output register.
// Reset: synchronous; clears list, position, running flag and tick counter,
// sets default and current wait to 1. Store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_playback_sequencer_core (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  tep_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  wire                         out_ready,
  output tep_pkg::out_item_t          out_data,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [tep_pkg::WAIT_W-1:0]   cfg_data
);

  tep_pkg::ctrl_cmd_t  cmd;
  tep_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tep_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
